// ===== hdl/mpcm_pkg.sv =====
// shared types, constants and helpers for the caseless multi-pattern matcher
// no dependencies; imported by every module of the block
package mpcm_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int PAT_BYTES   = 32;
  localparam int IDX_W       = 4;
  localparam int POS_W       = 5;
  localparam int LEN_W       = 6;
  localparam int LVL_W       = 3;
  localparam int TYP_W       = 4;
  localparam int ID_W        = 16;
  localparam int OFF_W       = 20;
  localparam int CNT_W       = OFF_W + 1;

  // command codes on the input channel
  localparam logic [1:0] CMD_WR_BYTE = 2'd0;
  localparam logic [1:0] CMD_WR_ATTR = 2'd1;
  localparam logic [1:0] CMD_SCAN    = 2'd2;

  // configuration register indexes
  localparam logic CFG_ACTIVE   = 1'b0;
  localparam logic CFG_CRITICAL = 1'b1;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PAT_BYTES);

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_ATTR,
    OP_SCAN
  } op_t;

  // classified item as it travels from front to back
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic [LVL_W-1:0] lvl;
    logic [TYP_W-1:0] typ;
    logic [ID_W-1:0]  id;
    logic             last;
  } item_t;

  // picture of the table and match record taken at the end of a scan
  typedef struct packed {
    logic [NUM_ENTRIES-1:0]            mask;
    logic [NUM_ENTRIES-1:0][LVL_W-1:0] lvl;
    logic [NUM_ENTRIES-1:0][TYP_W-1:0] typ;
    logic [NUM_ENTRIES-1:0][ID_W-1:0]  id;
    logic [NUM_ENTRIES-1:0][LEN_W-1:0] len;
    logic [NUM_ENTRIES-1:0][OFF_W-1:0] start;
  } snap_t;

  typedef struct packed {
    logic             detected;
    logic [LVL_W-1:0] level;
    logic [TYP_W-1:0] typ;
    logic [ID_W-1:0]  id;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] len;
  } result_t;

  // only A-Z fold to lower case
  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage

// ===== hdl/mpcm_front.sv =====
// front end: decodes and folds incoming items and holds them in a short queue
// depends on mpcm_pkg
module mpcm_front import mpcm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          cmd,
  input  logic [IDX_W-1:0]    pattern_index,
  input  logic [POS_W-1:0]    byte_position,
  input  logic [7:0]          data_byte,
  input  logic [LEN_W-1:0]    pattern_length,
  input  logic [LVL_W-1:0]    threat_level,
  input  logic [TYP_W-1:0]    threat_type,
  input  logic [ID_W-1:0]     sig_id,
  input  logic                last,
  output logic                head_valid,
  output item_t               head,
  input  logic                head_pop
);

  localparam int QD = 4;

  item_t        q_r [QD];
  logic [1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0]   cnt_r, cnt_nxt;
  item_t        cls;
  logic         keep;
  logic         wr;

  // classify the incoming item
  always_comb begin
    cls      = '0;
    keep     = 1'b1;
    cls.idx  = pattern_index;
    cls.pos  = byte_position;
    cls.data = fold(data_byte);
    cls.len  = (pattern_length > MAX_LEN) ? MAX_LEN : pattern_length;
    cls.lvl  = threat_level;
    cls.typ  = threat_type;
    cls.id   = sig_id;
    cls.last = last;
    case (cmd)
      CMD_WR_BYTE: cls.op = OP_BYTE;
      CMD_WR_ATTR: cls.op = OP_ATTR;
      CMD_SCAN:    cls.op = OP_SCAN;
      default: begin
        cls.op = OP_SCAN;
        keep   = 1'b0;
      end
    endcase
  end

  assign full       = (cnt_r == 3'(QD));
  assign wr         = push && !full && keep;
  assign head_valid = (cnt_r != 3'd0);
  assign head       = q_r[rp_r];

  // queue pointers
  always_comb begin
    wp_nxt  = wp_r + 2'(wr);
    rp_nxt  = rp_r + 2'(head_pop);
    cnt_nxt = cnt_r + 3'(wr) - 3'(head_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

// ===== hdl/mpcm_match.sv =====
// back end: pattern table, text window and parallel comparison of every entry
// depends on mpcm_pkg; feeds mpcm_report with a picture at each end of scan
module mpcm_match import mpcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  item_t       head,
  output logic        head_pop,
  input  logic        rep_free,
  input  logic [4:0]  active,
  output logic        snap_push,
  output snap_t       snap
);

  logic [7:0]       pat_r   [NUM_ENTRIES][PAT_BYTES];
  logic [LEN_W-1:0] len_r   [NUM_ENTRIES];
  logic [LVL_W-1:0] lvl_r   [NUM_ENTRIES];
  logic [TYP_W-1:0] typ_r   [NUM_ENTRIES];
  logic [ID_W-1:0]  id_r    [NUM_ENTRIES];
  logic [OFF_W-1:0] start_r [NUM_ENTRIES];
  logic [OFF_W-1:0] start_nxt [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] seen_r, seen_nxt, seen_upd;
  logic [PAT_BYTES-1:0][7:0] win_r, win_nxt, win_new;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_new;
  logic             go, scan, in_range;
  logic [NUM_ENTRIES-1:0] hit;
  logic [LEN_W-1:0] k6;

  // an end-of-scan item waits for a free report slot
  assign go       = head_valid && (head.op != OP_SCAN || !head.last || rep_free);
  assign head_pop = go;
  assign scan     = go && head.op == OP_SCAN;
  assign in_range = !cnt_r[CNT_W-1];
  assign win_new  = {win_r[PAT_BYTES-2:0], head.data};
  assign cnt_new  = cnt_r + CNT_W'(1);

  // every entry against the shifted window, one comparator per byte
  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      hit[e] = 1'b1;
      for (int j = 0; j < PAT_BYTES; j++) begin
        k6 = len_r[e] - LEN_W'(j + 1);
        if (LEN_W'(j) < len_r[e] && win_new[k6[POS_W-1:0]] != pat_r[e][j]) begin
          hit[e] = 1'b0;
        end
      end
    end
  end

  // match record and window update
  always_comb begin
    seen_upd = seen_r;
    win_nxt  = win_r;
    cnt_nxt  = cnt_r;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      start_nxt[e] = start_r[e];
    end
    if (go && head.op == OP_ATTR) begin
      seen_upd[head.idx] = 1'b0;
    end
    if (scan && in_range) begin
      win_nxt = win_new;
      cnt_nxt = cnt_new;
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        if (!seen_r[e] && len_r[e] != '0 && cnt_new >= CNT_W'(len_r[e]) && hit[e]) begin
          seen_upd[e]  = 1'b1;
          start_nxt[e] = OFF_W'(cnt_new - CNT_W'(len_r[e]));
        end
      end
    end
    seen_nxt = seen_upd;
    if (scan && head.last) begin
      seen_nxt = '0;
      win_nxt  = '0;
      cnt_nxt  = '0;
    end
  end

  // picture for the report stage
  assign snap_push = scan && head.last;
  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      snap.mask[e]  = seen_upd[e] && (5'(e) < active) && (lvl_r[e] != '0);
      snap.lvl[e]   = lvl_r[e];
      snap.typ[e]   = typ_r[e];
      snap.id[e]    = id_r[e];
      snap.len[e]   = len_r[e];
      snap.start[e] = start_nxt[e];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      win_r  <= '0;
      cnt_r  <= '0;
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        len_r[e] <= '0;
        lvl_r[e] <= '0;
        typ_r[e] <= '0;
        id_r[e]  <= '0;
      end
    end else begin
      seen_r <= seen_nxt;
      win_r  <= win_nxt;
      cnt_r  <= cnt_nxt;
      if (go && head.op == OP_ATTR) begin
        len_r[head.idx] <= head.len;
        lvl_r[head.idx] <= head.lvl;
        typ_r[head.idx] <= head.typ;
        id_r[head.idx]  <= head.id;
      end
    end
  end

  // pattern bytes and match starts need no reset
  always_ff @(posedge clk) begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      start_r[e] <= start_nxt[e];
    end
    if (go && head.op == OP_BYTE && LEN_W'(head.pos) < len_r[head.idx]) begin
      pat_r[head.idx][head.pos] <= head.data;
    end
  end

endmodule

// ===== hdl/mpcm_report.sv =====
// report stage: picks the winning entry and queues the result items
// depends on mpcm_pkg; fed by mpcm_match
module mpcm_report import mpcm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             snap_push,
  input  snap_t            snap,
  output logic             rep_free,
  input  logic [LVL_W-1:0] critical,
  output logic             empty,
  input  logic             pop,
  output result_t          res
);

  snap_t            snap_r;
  logic             sv_r, sv_nxt;
  result_t          oq_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             ofull, opush, opop;
  logic [LVL_W-1:0] tl [5][NUM_ENTRIES];
  logic [IDX_W-1:0] ti [5][NUM_ENTRIES];
  logic [IDX_W-1:0] crit_idx, win;
  logic             crit_hit;
  result_t          r;

  assign ofull    = (cnt_r == 2'd2);
  assign opush    = sv_r && !ofull;
  assign opop     = pop && !empty;
  assign rep_free = !sv_r || !ofull;
  assign empty    = (cnt_r == 2'd0);
  assign res      = oq_r[rp_r];

  // first matched entry at or above the critical level wins outright
  always_comb begin
    crit_hit = 1'b0;
    crit_idx = '0;
    for (int e = NUM_ENTRIES - 1; e >= 0; e--) begin
      if (snap_r.mask[e] && snap_r.lvl[e] >= critical) begin
        crit_hit = 1'b1;
        crit_idx = IDX_W'(e);
      end
    end
  end

  // otherwise highest level, lowest index on ties
  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      tl[0][e] = snap_r.mask[e] ? snap_r.lvl[e] : '0;
      ti[0][e] = IDX_W'(e);
    end
    for (int s = 1; s < 5; s++) begin
      for (int n = 0; n < NUM_ENTRIES; n++) begin
        tl[s][n] = '0;
        ti[s][n] = '0;
      end
      for (int n = 0; n < (NUM_ENTRIES >> s); n++) begin
        if (tl[s-1][2*n+1] > tl[s-1][2*n]) begin
          tl[s][n] = tl[s-1][2*n+1];
          ti[s][n] = ti[s-1][2*n+1];
        end else begin
          tl[s][n] = tl[s-1][2*n];
          ti[s][n] = ti[s-1][2*n];
        end
      end
    end
    win = crit_hit ? crit_idx : ti[4][0];
  end

  always_comb begin
    r = '0;
    if (snap_r.mask != '0) begin
      r.detected = 1'b1;
      r.level    = snap_r.lvl[win];
      r.typ      = snap_r.typ[win];
      r.id       = snap_r.id[win];
      r.offset   = snap_r.start[win];
      r.len      = snap_r.len[win];
    end
  end

  always_comb begin
    sv_nxt  = (sv_r && !opush) || snap_push;
    cnt_nxt = cnt_r + 2'(opush) - 2'(opop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r  <= 1'b0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      sv_r  <= sv_nxt;
      wp_r  <= wp_r ^ opush;
      rp_r  <= rp_r ^ opop;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_push) begin
      snap_r <= snap;
    end
    if (opush) begin
      oq_r[wp_r] <= r;
    end
  end

endmodule

// ===== hdl/multi_pattern_caseless_matcher.sv =====
// channel   direction  handshake        payload
// in_*      input      push / full      cmd, index, position, byte, attributes, last
// out_*     output     empty / pop      detected, level, type, id, offset, length
// cfg_*     input      valid / ready    index, data (active count, critical level)
//
// one item per cycle unless full is raised or a last byte waits for the report side; a scan
// byte is compared against all sixteen entries in the cycle it leaves the front queue, and
// the result passes through the registered picture and the winner stage into a two-deep result queue
// reset is synchronous and active low; the table attributes, window and records clear
// a full result queue holds only last bytes back; other items keep flowing
// top level: config registers, front, match and report; depends on mpcm_pkg
module multi_pattern_caseless_matcher import mpcm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             full,
  input  logic [1:0]       in_cmd,
  input  logic [IDX_W-1:0] in_pattern_index,
  input  logic [POS_W-1:0] in_byte_position,
  input  logic [7:0]       in_data_byte,
  input  logic [LEN_W-1:0] in_pattern_length,
  input  logic [LVL_W-1:0] in_threat_level,
  input  logic [TYP_W-1:0] in_threat_type,
  input  logic [ID_W-1:0]  in_sig_id,
  input  logic             in_last,
  output logic             empty,
  input  logic             pop,
  output logic             out_detected,
  output logic [LVL_W-1:0] out_level,
  output logic [TYP_W-1:0] out_winner_type,
  output logic [ID_W-1:0]  out_winner_id,
  output logic [OFF_W-1:0] out_offset,
  output logic [LEN_W-1:0] out_match_length,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [4:0]       cfg_data
);

  logic [4:0]       active_r;
  logic [LVL_W-1:0] crit_r;
  logic             head_valid, head_pop, rep_free, snap_push;
  item_t            head;
  snap_t            snap;
  result_t          res;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      crit_r   <= 3'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ACTIVE:   active_r <= cfg_data;
        CFG_CRITICAL: crit_r   <= cfg_data[LVL_W-1:0];
        default:      active_r <= active_r;
      endcase
    end
  end

  mpcm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (in_push),
    .full           (full),
    .cmd            (in_cmd),
    .pattern_index  (in_pattern_index),
    .byte_position  (in_byte_position),
    .data_byte      (in_data_byte),
    .pattern_length (in_pattern_length),
    .threat_level   (in_threat_level),
    .threat_type    (in_threat_type),
    .sig_id         (in_sig_id),
    .last           (in_last),
    .head_valid     (head_valid),
    .head           (head),
    .head_pop       (head_pop)
  );

  mpcm_match u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .rep_free   (rep_free),
    .active     (active_r),
    .snap_push  (snap_push),
    .snap       (snap)
  );

  mpcm_report u_report (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_push (snap_push),
    .snap      (snap),
    .rep_free  (rep_free),
    .critical  (crit_r),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign out_detected     = res.detected;
  assign out_level        = res.level;
  assign out_winner_type  = res.typ;
  assign out_winner_id    = res.id;
  assign out_offset       = res.offset;
  assign out_match_length = res.len;

  // result queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // a miss reports zero level, length, id and offset
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_detected |-> out_level == '0 && out_match_length == '0 &&
    out_winner_id == '0 && out_offset == '0)
    else $error("miss with nonzero fields");

  // a hit always carries a nonzero level and length
  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_detected |-> out_level != '0 && out_match_length != '0)
    else $error("hit with zero level or length");

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the caseless multi-pattern matcher
// drives table loads and scans, predicts the scan reports and checks them
// depends on mpcm_pkg and multi_pattern_caseless_matcher
`timescale 1ns / 1ps

module tb;
  import mpcm_pkg::*;

  localparam logic [1:0] CMD_NONE   = 2'd3;
  localparam int         SCAN_LIMIT = 1 << 20;
  localparam int         QUIET_MAX  = 5000;
  localparam int         HOLD_LEN   = 400;
  localparam int         DRAIN_CYC  = 20;

  typedef struct {
    bit [1:0]       cmd;
    bit [IDX_W-1:0] idx;
    bit [POS_W-1:0] pos;
    bit [7:0]       data;
    bit [LEN_W-1:0] len;
    bit [LVL_W-1:0] lvl;
    bit [TYP_W-1:0] typ;
    bit [ID_W-1:0]  id;
    bit             last;
  } stim_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             full;
  logic [1:0]       in_cmd = '0;
  logic [IDX_W-1:0] in_pattern_index = '0;
  logic [POS_W-1:0] in_byte_position = '0;
  logic [7:0]       in_data_byte = '0;
  logic [LEN_W-1:0] in_pattern_length = '0;
  logic [LVL_W-1:0] in_threat_level = '0;
  logic [TYP_W-1:0] in_threat_type = '0;
  logic [ID_W-1:0]  in_sig_id = '0;
  logic             in_last = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic             out_detected;
  logic [LVL_W-1:0] out_level;
  logic [TYP_W-1:0] out_winner_type;
  logic [ID_W-1:0]  out_winner_id;
  logic [OFF_W-1:0] out_offset;
  logic [LEN_W-1:0] out_match_length;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = 1'b0;
  logic [4:0]       cfg_data = '0;

  multi_pattern_caseless_matcher u_top (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  bit [7:0]       tbl_byte [NUM_ENTRIES][PAT_BYTES];
  bit [LEN_W-1:0] ent_len [NUM_ENTRIES];
  bit [LVL_W-1:0] ent_lvl [NUM_ENTRIES];
  bit [TYP_W-1:0] ent_typ [NUM_ENTRIES];
  bit [ID_W-1:0]  ent_id [NUM_ENTRIES];
  bit [7:0]       win [PAT_BYTES];
  int unsigned    scan_cnt;
  bit [OFF_W-1:0] first_start [NUM_ENTRIES];
  bit             seen [NUM_ENTRIES];
  int unsigned    act_cnt = 0;
  bit [LVL_W-1:0] crit_lvl = 3'd4;

  // stimulus shadow of the table, used to keep every compared byte written
  bit [7:0]       gen_pat [NUM_ENTRIES][PAT_BYTES];
  bit             gen_wr [NUM_ENTRIES][PAT_BYTES];
  int             gen_len [NUM_ENTRIES];
  bit             gen_dirty;

  stim_t   pend_q[$];
  result_t due_reports[$];
  stim_t   cur;
  int      gap_in;
  int      wait_out;
  int      hold_left;
  bit      hold_start;
  bit      idle_in, idle_out;
  int      errors, n_items, n_reports, n_hits, n_settings, quiet;

  function automatic bit [7:0] to_lower(bit [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // one accepted item through the predictor
  task automatic match_step(stim_t s);
    int      l, best;
    bit      hit;
    bit [2:0] bl;
    result_t r;
    case (s.cmd)
      CMD_WR_BYTE:
        if (s.pos < ent_len[s.idx]) tbl_byte[s.idx][s.pos] = s.data;
      CMD_WR_ATTR: begin
        ent_len[s.idx] = (s.len > PAT_BYTES) ? LEN_W'(PAT_BYTES) : s.len;
        ent_lvl[s.idx] = s.lvl;
        ent_typ[s.idx] = s.typ;
        ent_id[s.idx] = s.id;
        seen[s.idx] = 1'b0;
        first_start[s.idx] = '0;
      end
      CMD_SCAN: begin
        if (scan_cnt < SCAN_LIMIT) begin
          for (int k = PAT_BYTES - 1; k > 0; k--) win[k] = win[k-1];
          win[0] = s.data;
          scan_cnt++;
          for (int e = 0; e < NUM_ENTRIES; e++) begin
            l = ent_len[e];
            if (seen[e] || l == 0 || scan_cnt < l) continue;
            hit = 1'b1;
            for (int j = 0; j < l; j++)
              if (to_lower(win[l-1-j]) != to_lower(tbl_byte[e][j])) hit = 1'b0;
            if (hit) begin
              seen[e] = 1'b1;
              first_start[e] = OFF_W'(scan_cnt - l);
            end
          end
        end
        if (s.last) begin
          // highest level wins, lowest index on ties, stop at critical level
          best = NUM_ENTRIES;
          bl = '0;
          for (int e = 0; e < ((act_cnt > NUM_ENTRIES) ? NUM_ENTRIES : act_cnt); e++)
            if (seen[e] && ent_lvl[e] > bl) begin
              best = e;
              bl = ent_lvl[e];
              if (bl >= crit_lvl) break;
            end
          r = '0;
          if (best < NUM_ENTRIES) begin
            r.detected = 1'b1;
            r.level = bl;
            r.typ = ent_typ[best];
            r.id = ent_id[best];
            r.offset = first_start[best];
            r.len = ent_len[best];
          end
          due_reports.push_back(r);
          for (int k = 0; k < PAT_BYTES; k++) win[k] = '0;
          for (int e = 0; e < NUM_ENTRIES; e++) begin
            seen[e] = 1'b0;
            first_start[e] = '0;
          end
          scan_cnt = 0;
        end
      end
      default: ;
    endcase
  endtask

  // driver: offers queued items, one random gap per item when idle_in is set
  always @(posedge clk) begin
    bit sent, push_n;
    sent = 1'b0;
    if (!rst_n) begin
      gap_in = 0;
      push_n = 1'b0;
    end else begin
      if (in_push && !full) begin
        match_step(cur);
        n_items++;
        sent = 1'b1;
      end
      if (in_push && !sent) push_n = 1'b1;
      else if (gap_in > 0) begin
        gap_in--;
        push_n = 1'b0;
      end else if (pend_q.size() > 0) begin
        cur = pend_q.pop_front();
        in_cmd <= cur.cmd;
        in_pattern_index <= cur.idx;
        in_byte_position <= cur.pos;
        in_data_byte <= cur.data;
        in_pattern_length <= cur.len;
        in_threat_level <= cur.lvl;
        in_threat_type <= cur.typ;
        in_sig_id <= cur.id;
        in_last <= cur.last;
        push_n = 1'b1;
        gap_in = idle_in ? $urandom_range(0, 16) : 0;
      end else push_n = 1'b0;
    end
    in_push <= push_n;
  end

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got %0h, expected %0h (report %0d)", what, got, want, n_reports);
    errors++;
  endtask

  // monitor: takes results, checks them against the oldest due report
  always @(posedge clk) begin
    result_t w;
    if (!rst_n) begin
      wait_out = 0;
      hold_left = 0;
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_reports++;
        if (due_reports.size() == 0) report("unexpected report", 1, 0);
        else begin
          w = due_reports.pop_front();
          if (out_detected !== w.detected) report("detected", out_detected, w.detected);
          if (out_level !== w.level) report("level", out_level, w.level);
          if (out_winner_type !== w.typ) report("winner_type", out_winner_type, w.typ);
          if (out_winner_id !== w.id) report("winner_id", out_winner_id, w.id);
          if (out_offset !== w.offset) report("offset", out_offset, w.offset);
          if (out_match_length !== w.len) report("match_length", out_match_length, w.len);
          if (w.detected) n_hits++;
        end
        wait_out = idle_out ? $urandom_range(0, 16) : 0;
      end else if (wait_out > 0) wait_out--;
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) hold_left--;
      pop <= (wait_out == 0 && hold_left == 0);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_MAX) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic bit [7:0] text_byte();
    case ($urandom_range(0, 9))
      0, 1: return "a";
      2, 3: return "A";
      4, 5: return "b";
      6:    return "B";
      7:    return "Z";
      8:    return "c";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic stim_t noise_item();
    stim_t s;
    s.cmd = 2'($urandom_range(0, 3));
    s.idx = 4'($urandom);
    s.pos = 5'($urandom);
    s.data = 8'($urandom);
    s.len = 6'($urandom);
    s.lvl = 3'($urandom);
    s.typ = 4'($urandom);
    s.id = 16'($urandom);
    s.last = 1'($urandom);
    return s;
  endfunction

  // queue one item, first filling any table byte a scan would compare
  task automatic emit(stim_t s);
    stim_t f;
    while (pend_q.size() > 64) @(posedge clk);
    if (s.cmd == CMD_SCAN && gen_dirty) begin
      for (int e = 0; e < NUM_ENTRIES; e++)
        for (int p = 0; p < gen_len[e]; p++)
          if (!gen_wr[e][p]) begin
            f = noise_item();
            f.cmd = CMD_WR_BYTE;
            f.idx = IDX_W'(e);
            f.pos = POS_W'(p);
            f.data = text_byte();
            gen_wr[e][p] = 1'b1;
            gen_pat[e][p] = f.data;
            pend_q.push_back(f);
          end
      gen_dirty = 1'b0;
    end
    if (s.cmd == CMD_WR_ATTR) begin
      gen_len[s.idx] = (s.len > PAT_BYTES) ? PAT_BYTES : s.len;
      gen_dirty = 1'b1;
    end
    if (s.cmd == CMD_WR_BYTE && s.pos < gen_len[s.idx]) begin
      gen_wr[s.idx][s.pos] = 1'b1;
      gen_pat[s.idx][s.pos] = s.data;
    end
    pend_q.push_back(s);
  endtask

  task automatic load_entry(int e, int l, int lv, int ty, int pid);
    stim_t s;
    s = noise_item();
    s.cmd = CMD_WR_ATTR;
    s.idx = IDX_W'(e);
    s.len = LEN_W'(l);
    s.lvl = LVL_W'(lv);
    s.typ = TYP_W'(ty);
    s.id = ID_W'(pid);
    emit(s);
    for (int p = 0; p < ((l > PAT_BYTES) ? PAT_BYTES : l); p++) begin
      s = noise_item();
      s.cmd = CMD_WR_BYTE;
      s.idx = IDX_W'(e);
      s.pos = POS_W'(p);
      s.data = text_byte();
      emit(s);
    end
  endtask

  task automatic scan_byte(bit [7:0] b, bit lst);
    stim_t s;
    s = noise_item();
    s.cmd = CMD_SCAN;
    s.data = b;
    s.last = lst;
    emit(s);
  endtask

  // scan of random text, sometimes with a stored pattern planted in it
  task automatic random_scan();
    int n, e, at;
    bit [7:0] b;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    e = $urandom_range(0, NUM_ENTRIES - 1);
    at = (gen_len[e] > 0 && $urandom_range(0, 2) != 0) ? $urandom_range(0, n - 1) : n;
    for (int k = 0; k < n; k++) begin
      if (k >= at && k - at < gen_len[e]) begin
        b = gen_pat[e][k - at];
        if ($urandom_range(0, 1) && to_lower(b) >= "a" && to_lower(b) <= "z")
          b = to_lower(b) - 8'd32;
      end else b = text_byte();
      scan_byte(b, k == n - 1);
    end
  endtask

  task automatic random_phase(int n_target, bit with_hold);
    int done;
    int r;
    stim_t s;
    done = 0;
    while (done < n_target) begin
      if (with_hold && done > n_target / 3 && done < n_target / 3 + 10) hold_start = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        r = $urandom_range(0, 19);
        load_entry($urandom_range(0, NUM_ENTRIES - 1),
                   (r == 0) ? 0 : (r == 1) ? $urandom_range(5, 63) : $urandom_range(1, 4),
                   $urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 65535));
        done += 5;
      end else if (r < 12) begin
        s = noise_item();
        if (s.cmd == CMD_SCAN) s.cmd = CMD_NONE;
        emit(s);
        done++;
      end else begin
        random_scan();
        done += 8;
      end
    end
  endtask

  task automatic write_reg(bit ri, bit [4:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (ri == CFG_ACTIVE) act_cnt = v;
    else crit_lvl = v[2:0];
    n_settings++;
  endtask

  // block idle: no pending item, no report due, pipeline drained
  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (pend_q.size() > 0 || in_push || due_reports.size() > 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: nothing active, so a scan reports no detection
    idle_in = 0;
    idle_out = 0;
    load_entry(0, 1, 7, 15, 16'hffff);
    scan_byte(gen_pat[0][0], 1'b1);
    settle();

    // directed: extremes, caseless match, zero level, unused command, long length
    write_reg(CFG_ACTIVE, 5'd16);
    write_reg(CFG_CRITICAL, 5'b11111);
    load_entry(0, 2, 7, 15, 16'hffff);
    load_entry(1, 1, 0, 3, 16'h1234);
    load_entry(2, 0, 6, 2, 16'h0001);
    pend_q.push_back('{CMD_WR_BYTE, 4'd0, 5'd31, 8'hff, 6'd0, 3'd0, 4'd0, 16'd0, 1'b0});
    pend_q.push_back('{CMD_NONE, 4'hf, 5'h1f, 8'hff, 6'h3f, 3'd7, 4'hf, 16'hffff, 1'b1});
    scan_byte(gen_pat[1][0], 1'b0);
    scan_byte(gen_pat[0][0], 1'b0);
    scan_byte(gen_pat[0][1], 1'b1);
    scan_byte(gen_pat[1][0], 1'b1);
    load_entry(3, 63, 1, 0, 16'h0000);
    random_scan();
    settle();

    // random phases over several settings
    idle_in = 1;
    idle_out = 1;
    random_phase(300, 1'b1);
    settle();
    write_reg(CFG_ACTIVE, 5'd5);
    write_reg(CFG_CRITICAL, 5'b01000);
    idle_in = 0;
    random_phase(300, 1'b0);
    settle();
    write_reg(CFG_ACTIVE, 5'd31);
    write_reg(CFG_CRITICAL, 5'd3);
    idle_in = 1;
    idle_out = 0;
    random_phase(300, 1'b0);
    settle();
    write_reg(CFG_ACTIVE, 5'd1);
    write_reg(CFG_CRITICAL, 5'd7);
    idle_out = 1;
    random_phase(300, 1'b1);
    settle();
    write_reg(CFG_ACTIVE, 5'd16);
    write_reg(CFG_CRITICAL, 5'd4);
    random_phase(300, 1'b0);
    settle();

    $display("covered %0d items, %0d scan reports with %0d detections", n_items, n_reports, n_hits);
    $display("over %0d register writes and long hold-offs on the result side", n_settings);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mpcm_pkg.sv
hdl/mpcm_front.sv
hdl/mpcm_match.sv
hdl/mpcm_report.sv
hdl/multi_pattern_caseless_matcher.sv
dv/tb.sv
